// ----- design/ptw_pkg.sv -----
// ============================================================================
// Page table walker package
// Shared widths, codes, types and helpers for the four-level walker.
// ============================================================================
`default_nettype none

package ptw_pkg;

    localparam int LA_BITS            = 48;
    localparam int ENTRY_BITS         = 64;
    localparam int ADDR_BITS          = 52;
    localparam int ROOT_BITS          = 40;
    localparam int LEVEL_BITS         = 2;
    localparam int INDEX_BITS         = 9;
    localparam int PAGE_SHIFT         = 12;
    localparam int DEF_PHYS_ADDR_BITS = 52;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    typedef enum logic
    {
        KIND_REQUEST = 1'b0,
        KIND_ENTRY   = 1'b1
    } in_kind_t;

    typedef enum logic
    {
        RES_READ = 1'b0,
        RES_DONE = 1'b1
    } res_kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK          = 2'd0,
        STATUS_NOT_PRESENT = 2'd1,
        STATUS_NO_WALK     = 2'd2
    } walk_status_t;

    localparam logic [LEVEL_BITS-1:0] LEVEL_TOP  = 2'd0;
    localparam logic [LEVEL_BITS-1:0] LEVEL_2ND  = 2'd1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_3RD  = 2'd2;
    localparam logic [LEVEL_BITS-1:0] LEVEL_LAST = 2'd3;

    typedef struct packed
    {
        logic                  active;
        logic [LEVEL_BITS-1:0] level;
        logic [LA_BITS-1:0]    la;
    } walk_state_t;

    typedef struct packed
    {
        walk_status_t          status;
        logic [ENTRY_BITS-1:0] value;
        logic [LEVEL_BITS-1:0] level;
        logic [ADDR_BITS-1:0]  read_address;
    } result_t;

    function automatic logic [INDEX_BITS-1:0] table_index(
        input logic [LA_BITS-1:0]    la,
        input logic [LEVEL_BITS-1:0] level
    );
        logic [INDEX_BITS-1:0] idx;
        begin
            unique case (level)
                LEVEL_TOP:  idx = la[47:39];
                LEVEL_2ND:  idx = la[38:30];
                LEVEL_3RD:  idx = la[29:21];
                default:    idx = la[20:12];
            endcase
            return idx;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/ptw_step.sv -----
// ============================================================================
// Page table walker step
// Handles one item: works out the result and the next walk state.
// ============================================================================
`default_nettype none

module ptw_step
    import ptw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = DEF_PHYS_ADDR_BITS
)
(
    input  wire logic [ROOT_BITS-1:0]  root_table_frame,
    input  wire walk_state_t           state_cur,
    input  wire in_kind_t              kind,
    input  wire logic [LA_BITS-1:0]    linear_address,
    input  wire logic [ENTRY_BITS-1:0] entry_data,
    output walk_state_t                state_next,
    output res_kind_t                  res_kind,
    output result_t                    res
);

    localparam int FRAME_BITS = PHYS_ADDR_BITS - PAGE_SHIFT;

    logic                      present;
    logic                      large_page;
    logic                      ends;
    logic [LEVEL_BITS-1:0]     level_up;
    logic [FRAME_BITS-1:0]     frame;
    logic [LEVEL_BITS-1:0]     addr_level;
    logic [LA_BITS-1:0]        addr_la;
    logic [INDEX_BITS-1:0]     idx;
    logic [PHYS_ADDR_BITS-1:0] phys_addr;

    assign present    = entry_data[PRESENT_BIT];
    assign large_page = entry_data[LARGE_BIT];
    assign ends       = (state_cur.level == LEVEL_LAST)
                     || (((state_cur.level == LEVEL_2ND) || (state_cur.level == LEVEL_3RD))
                         && large_page);
    assign level_up   = state_cur.level + LEVEL_BITS'(1);

    always_comb
    begin
        if (kind == KIND_REQUEST)
        begin
            frame      = root_table_frame[FRAME_BITS-1:0];
            addr_level = LEVEL_TOP;
            addr_la    = linear_address;
        end
        else
        begin
            frame      = entry_data[PAGE_SHIFT +: FRAME_BITS];
            addr_level = level_up;
            addr_la    = state_cur.la;
        end
    end

    assign idx       = table_index(addr_la, addr_level);
    assign phys_addr = {frame, idx, 3'b000};

    always_comb
    begin
        state_next       = state_cur;
        res_kind         = RES_DONE;
        res.status       = STATUS_OK;
        res.value        = '0;
        res.level        = LEVEL_TOP;
        res.read_address = '0;
        if (kind == KIND_REQUEST)
        begin
            state_next.active = 1'b1;
            state_next.level  = LEVEL_TOP;
            state_next.la     = linear_address;
            res_kind          = RES_READ;
            res.read_address  = ADDR_BITS'(phys_addr);
        end
        else if (!state_cur.active)
        begin
            res.status = STATUS_NO_WALK;
        end
        else
        begin
            res.value = entry_data;
            res.level = state_cur.level;
            if (!present || ends)
            begin
                state_next.active = 1'b0;
                state_next.level  = LEVEL_TOP;
                res.status        = present ? STATUS_OK : STATUS_NOT_PRESENT;
            end
            else
            begin
                state_next.level = level_up;
                res_kind         = RES_READ;
                res.read_address = ADDR_BITS'(phys_addr);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/four_level_page_table_walker.sv -----
// ============================================================================
// Four-level page table walker
// Walks 48-bit linear addresses through four levels of page tables, issuing
// one entry read request per level and finishing on a leaf or a fault.
// ============================================================================
//
// Channel  Direction  Handshake          Contents
// s        in         s_tvalid/s_tready  request or returned entry
// m        out        m_tvalid/m_tready  read request or walk result
// cfg      in         cfg_we             root table frame
//
// An item passes an input register and then a result register, and one item
// is taken every cycle while the result side keeps up. The walk state is
// updated as each item leaves the input register, so the next item always
// sees it. Reset idles the walker and clears both stages. When the result
// is not taken, the input register holds one further item.
//
`default_nettype none

module four_level_page_table_walker
    import ptw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = DEF_PHYS_ADDR_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [ROOT_BITS-1:0] cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [47:0] linear_address, [111:48] entry_data
    input  wire logic [111:0]         s_tdata,
    // [0] kind
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [51:0] read_address, [53:52] entry_level, [117:54] entry_value,
    // [119:118] walk_status
    output logic [119:0]              m_tdata,
    // [0] result_kind
    output logic                      m_tuser
);

    logic [ROOT_BITS-1:0]  root_reg;
    walk_state_t           walk_reg;
    walk_state_t           walk_next;
    logic                  in_valid_reg;
    in_kind_t              in_kind_reg;
    logic [LA_BITS-1:0]    in_la_reg;
    logic [ENTRY_BITS-1:0] in_entry_reg;
    logic                  out_valid_reg;
    res_kind_t             out_kind_reg;
    result_t               out_res_reg;
    res_kind_t             step_kind;
    result_t               step_res;
    logic                  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ptw_step #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_step (
        .root_table_frame (root_reg),
        .state_cur        (walk_reg),
        .kind             (in_kind_reg),
        .linear_address   (in_la_reg),
        .entry_data       (in_entry_reg),
        .state_next       (walk_next),
        .res_kind         (step_kind),
        .res              (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            walk_reg      <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                root_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                walk_reg      <= walk_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg  <= in_kind_t'(s_tuser);
            in_la_reg    <= s_tdata[47:0];
            in_entry_reg <= s_tdata[111:48];
        end
        if (advance)
        begin
            out_kind_reg <= step_kind;
            out_res_reg  <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_res_reg;

    a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_kind == RES_DONE) |=> !walk_reg.active)
        else $error("walker still active after a finishing result");

    a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_kind_reg == KIND_REQUEST)
        |=> (walk_reg.active && walk_reg.level == LEVEL_TOP))
        else $error("request did not start a walk at the top level");

    a_level_needs_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_reg.level != LEVEL_TOP) |-> walk_reg.active)
        else $error("non-zero level while no walk is active");

    a_fault_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_res_reg.status == STATUS_NOT_PRESENT
                      || out_res_reg.status == STATUS_NO_WALK))
        |-> (m_tuser == RES_DONE && out_res_reg.read_address == '0))
        else $error("failure result carries a read request");

endmodule

`default_nettype wire
